// ===== src/aiks_pkg.sv =====
// ----------------------------------------------------------------------------
// aiks_pkg
// Shared types, register indexes and fixed-point constants of the arm solver.
// ----------------------------------------------------------------------------
package aiks_pkg;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [17:0] angle_t;

  // request to the shared divide / square-root unit
  typedef struct packed {
    logic start;
    logic mode;
  } ds_req_t;

  localparam logic DS_DIV  = 1'b0;
  localparam logic DS_SQRT = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_ARM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREARM_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRIST_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN   = 3'd4;

  localparam logic OP_TARGET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam int ATAN_N = 24;
  localparam logic signed [28:0] PI_Q24      = 29'sd52707179;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

  // arctangent of 2^-i in Q.24 radians
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] v;
    unique case (i)
      5'd0:    v = 24'd13176795;
      5'd1:    v = 24'd7778716;
      5'd2:    v = 24'd4110060;
      5'd3:    v = 24'd2086331;
      5'd4:    v = 24'd1047214;
      5'd5:    v = 24'd524117;
      5'd6:    v = 24'd262123;
      5'd7:    v = 24'd131069;
      5'd8:    v = 24'd65536;
      5'd9:    v = 24'd32768;
      5'd10:   v = 24'd16384;
      5'd11:   v = 24'd8192;
      5'd12:   v = 24'd4096;
      5'd13:   v = 24'd2048;
      5'd14:   v = 24'd1024;
      5'd15:   v = 24'd512;
      5'd16:   v = 24'd256;
      5'd17:   v = 24'd128;
      5'd18:   v = 24'd64;
      5'd19:   v = 24'd32;
      5'd20:   v = 24'd16;
      5'd21:   v = 24'd8;
      5'd22:   v = 24'd4;
      5'd23:   v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/aiks_ifs.sv =====
// ----------------------------------------------------------------------------
// aiks channel interfaces
// Valid/ready channels for target items, results and register writes.
// ----------------------------------------------------------------------------
interface aiks_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  aiks_pkg::coord_t   target_x;
  aiks_pkg::coord_t   target_y;
  aiks_pkg::coord_t   target_z;
  modport source(output valid, operation, target_x, target_y, target_z, input ready);
  modport sink(input valid, operation, target_x, target_y, target_z, output ready);
endinterface

interface aiks_out_if;
  logic               valid;
  logic               ready;
  aiks_pkg::angle_t   goal_base;
  aiks_pkg::angle_t   goal_shoulder;
  aiks_pkg::angle_t   goal_elbow;
  aiks_pkg::angle_t   goal_wrist;
  aiks_pkg::angle_t   drive_base;
  aiks_pkg::angle_t   drive_shoulder;
  aiks_pkg::angle_t   drive_elbow;
  aiks_pkg::angle_t   drive_wrist;
  logic               out_of_reach;
  modport source(output valid, goal_base, goal_shoulder, goal_elbow, goal_wrist,
                 drive_base, drive_shoulder, drive_elbow, drive_wrist, out_of_reach,
                 input ready);
  modport sink(input valid, goal_base, goal_shoulder, goal_elbow, goal_wrist,
               drive_base, drive_shoulder, drive_elbow, drive_wrist, out_of_reach,
               output ready);
endinterface

interface aiks_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aiks_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/aiks_mul.sv =====
// ----------------------------------------------------------------------------
// aiks_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module aiks_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);
  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 66'(a) * 66'(b);
  end

  assign prod = prod_r;
endmodule

// ===== src/aiks_divsqrt.sv =====
// ----------------------------------------------------------------------------
// aiks_divsqrt
// Shared restoring divider and digit-by-digit square root, one bit a cycle.
// ----------------------------------------------------------------------------
module aiks_divsqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  aiks_pkg::ds_req_t   req,
  input  logic [63:0]         op_a,
  input  logic [29:0]         den,
  output logic                done,
  output logic [31:0]         result
);
  import aiks_pkg::*;

  localparam logic [5:0] DIV_STEPS  = 6'd31;
  localparam logic [5:0] SQRT_STEPS = 6'd32;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        mode_r, mode_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] opa_r, opa_nxt;
  logic [29:0] den_r, den_nxt;

  logic [35:0] rem2, sub_a, sub_b, sel;
  logic [36:0] diff;
  logic        q_bit;

  // one shared subtractor: divisor for divide, trial root for square root
  always_comb begin
    rem2  = {rem_r[33:0], opa_r[63:62]};
    sub_a = (mode_r == DS_DIV) ? rem_r : rem2;
    sub_b = (mode_r == DS_DIV) ? {6'b0, den_r} : {2'b0, acc_r, 2'b01};
    diff  = {1'b0, sub_a} - {1'b0, sub_b};
    q_bit = ~diff[36];
    sel   = q_bit ? diff[35:0] : sub_a;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      cnt_nxt  = (req.mode == DS_DIV) ? DIV_STEPS : SQRT_STEPS;
      rem_nxt  = (req.mode == DS_DIV) ? op_a[35:0] : 36'd0;
      acc_nxt  = 32'd0;
      opa_nxt  = op_a;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = (mode_r == DS_DIV) ? {sel[34:0], 1'b0} : sel;
      acc_nxt = {acc_r[30:0], q_bit};
      opa_nxt = {opa_r[61:0], 2'b00};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    den_r  <= den_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;
endmodule

// ===== src/aiks_cordic.sv =====
// ----------------------------------------------------------------------------
// aiks_cordic
// Vectoring CORDIC atan2: half-plane fold, normalizing shifts, then rotations.
// ----------------------------------------------------------------------------
module aiks_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [43:0] y_in,
  input  logic signed [43:0] x_in,
  output logic               done,
  output logic signed [28:0] angle
);
  import aiks_pkg::*;

  localparam int N = (STEPS < ATAN_N) ? STEPS : ATAN_N;
  localparam logic [4:0] LAST = 5'(N - 1);
  localparam logic signed [45:0] COARSE_LIMIT = 46'sd1 <<< 32;
  localparam logic signed [45:0] NORM_LIMIT   = 46'sd1 <<< 40;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  logic [1:0]         cst_r, cst_nxt;
  logic               done_r, done_nxt;
  logic signed [45:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [28:0] z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;

  logic signed [45:0] ay, mag, xs, ys;
  logic signed [28:0] step_ang;

  always_comb begin
    ay       = y_r[45] ? -y_r : y_r;
    mag      = (x_r > ay) ? x_r : ay;
    xs       = x_r >>> i_r;
    ys       = y_r >>> i_r;
    step_ang = $signed({5'b0, atan_q24(i_r)});
  end

  always_comb begin
    cst_nxt  = cst_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    unique case (cst_r)
      C_IDLE: begin
        if (start) begin
          i_nxt = 5'd0;
          if (x_in == 44'sd0 && y_in == 44'sd0) begin
            z_nxt    = 29'sd0;
            done_nxt = 1'b1;
          end else if (x_in < 44'sd0) begin
            // fold the left half plane onto the right one
            x_nxt   = -46'(x_in);
            y_nxt   = -46'(y_in);
            z_nxt   = (y_in >= 44'sd0) ? PI_Q24 : -PI_Q24;
            cst_nxt = C_NORM;
          end else begin
            x_nxt   = 46'(x_in);
            y_nxt   = 46'(y_in);
            z_nxt   = 29'sd0;
            cst_nxt = C_NORM;
          end
        end
      end
      C_NORM: begin
        if (mag < COARSE_LIMIT) begin
          x_nxt = x_r <<< 8;
          y_nxt = y_r <<< 8;
        end else if (mag < NORM_LIMIT) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          cst_nxt = C_ITER;
        end
      end
      C_ITER: begin
        if (!y_r[45]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + step_ang;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - step_ang;
        end
        i_nxt = i_r + 5'd1;
        if (i_r == LAST) begin
          cst_nxt  = C_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: cst_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      cst_r  <= cst_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

  assign done  = done_r;
  assign angle = z_r;
endmodule

// ===== src/arm_inverse_kinematics_smoother.sv =====
// ----------------------------------------------------------------------------
// arm_inverse_kinematics_smoother
// Closed-form inverse kinematics for a yaw-plus-planar arm, with smoothing.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: operation 0 is a target point
//   (x, y, z in Q12.4 mm), operation 1 is a control tick. Every item gives
//   exactly one transfer on out_ch with the four goal angles, the four drive
//   commands after the item (Q4.13 rad) and the out-of-reach flag.
//   cfg_ch writes link lengths and the smoothing gain; it is always ready
//   and is meant to be used only while no item is in flight.
// Throughput and work per item:
//   The block takes one item at a time; in_ch is ready only when idle.
//   A target runs nine multiplies on the shared multiplier, a 31-step
//   divide (skipped on a clamped cosine or a zero link product) and two
//   32-step square roots on the shared divide/root unit, and four atan2
//   passes on the shared CORDIC unit, whose normalizing shifts depend on
//   the operand size.
//   A tick runs one multiply and accumulate per joint.
// Reset:
//   rst_n (synchronous, active low) restores default link lengths and gain,
//   clears goals, drives and the flag, and empties the result register.
// Stall:
//   The result register holds while out_ch is stalled; the next item is
//   still taken and worked on, and waits at its end for the register.
// ----------------------------------------------------------------------------
module arm_inverse_kinematics_smoother #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aiks_in_if.sink    in_ch,
  aiks_out_if.source out_ch,
  aiks_cfg_if.sink   cfg_ch
);
  import aiks_pkg::*;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_XX   = 5'd1;   // x*x
  localparam logic [4:0] ST_YY   = 5'd2;   // y*y
  localparam logic [4:0] ST_HH   = 5'd3;   // h*h
  localparam logic [4:0] ST_L22  = 5'd4;   // L2*L2
  localparam logic [4:0] ST_L33  = 5'd5;   // L3*L3
  localparam logic [4:0] ST_L23  = 5'd6;   // L2*L3
  localparam logic [4:0] ST_DEN  = 5'd7;
  localparam logic [4:0] ST_CHK  = 5'd8;   // reach check, launch divide
  localparam logic [4:0] ST_DIV  = 5'd9;
  localparam logic [4:0] ST_CC   = 5'd10;  // c*c
  localparam logic [4:0] ST_SQS  = 5'd11;
  localparam logic [4:0] ST_SQW  = 5'd12;
  localparam logic [4:0] ST_RS   = 5'd13;
  localparam logic [4:0] ST_RW   = 5'd14;
  localparam logic [4:0] ST_LS   = 5'd15;  // L3*s
  localparam logic [4:0] ST_LC   = 5'd16;  // L3*c
  localparam logic [4:0] ST_LCW  = 5'd17;
  localparam logic [4:0] ST_CST  = 5'd18;
  localparam logic [4:0] ST_CWT  = 5'd19;
  localparam logic [4:0] ST_FIN  = 5'd20;
  localparam logic [4:0] ST_TKM  = 5'd21;  // (goal-drive)*gain
  localparam logic [4:0] ST_TKA  = 5'd22;
  localparam logic [4:0] ST_OUT  = 5'd23;

  // atan2 passes, in the order they run
  localparam logic [1:0] CA_ELBOW = 2'd0;  // atan2(s, c)
  localparam logic [1:0] CA_REACH = 2'd1;  // atan2(h, R)
  localparam logic [1:0] CA_LINK  = 2'd2;  // atan2(L3*s, L2 + L3*c)
  localparam logic [1:0] CA_BASE  = 2'd3;  // atan2(y, x)

  localparam logic [1:0] JNT_BASE     = 2'd0;
  localparam logic [1:0] JNT_SHOULDER = 2'd1;
  localparam logic [1:0] JNT_ELBOW    = 2'd2;
  localparam logic [1:0] JNT_WRIST    = 2'd3;

  localparam logic signed [31:0] C_ONE   = 32'sd1073741824;
  localparam logic [63:0]        ONE_SQR = 64'd1 << 60;

  function automatic angle_t rnd_q13(input logic signed [29:0] v);
    logic signed [29:0] t;
    t = v + 30'sd1024;
    return t[28:11];
  endfunction

  logic [4:0]  state_r, state_nxt;
  logic [9:0]  l1_r, l2_r, l3_r, l4_r;
  logic [15:0] gain_r;

  coord_t             x_r, x_nxt, y_r, y_nxt;
  logic signed [17:0] h_r, h_nxt;
  logic [32:0]        r2_r, r2_nxt;
  logic signed [35:0] num_r, num_nxt;
  logic [29:0]        den_r, den_nxt;
  logic signed [31:0] c_r, c_nxt;
  logic [30:0]        s_r, s_nxt;
  logic [15:0]        rr_r, rr_nxt;
  logic signed [43:0] q3y_r, q3y_nxt, q3x_r, q3x_nxt;
  logic signed [28:0] ang_r [4];
  logic signed [28:0] ang_nxt [4];
  logic [1:0]         k_r, k_nxt, j_r, j_nxt;
  angle_t             goal_r [4];
  angle_t             goal_nxt [4];
  angle_t             drive_r [4];
  angle_t             drive_nxt [4];
  logic               flag_r, flag_nxt;

  angle_t             out_goal_r [4];
  angle_t             out_goal_nxt [4];
  angle_t             out_drive_r [4];
  angle_t             out_drive_nxt [4];
  logic               out_flag_r, out_flag_nxt;
  logic               out_valid_r, out_valid_nxt;

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  ds_req_t            ds_req;
  logic [63:0]        ds_opa;
  logic               ds_done;
  logic [31:0]        ds_result;
  logic               cr_start, cr_done;
  logic signed [43:0] cr_y, cr_x;
  logic signed [28:0] cr_angle;

  logic signed [17:0] neg_z, lift, h_calc;
  logic signed [10:0] ldiff;
  logic signed [35:0] den_s;
  logic [35:0]        num_mag;
  logic signed [18:0] diff_j;
  logic [31:0]        quot;
  angle_t             elbow_q, shoulder_q, base_q, wrist_q;

  aiks_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  aiks_divsqrt u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ds_req),
    .op_a   (ds_opa),
    .den    (den_r),
    .done   (ds_done),
    .result (ds_result)
  );

  aiks_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cr_start),
    .y_in  (cr_y),
    .x_in  (cr_x),
    .done  (cr_done),
    .angle (cr_angle)
  );

  // height of the wrist target above the shoulder: -z + (L1 - L4) in Q.4
  always_comb begin
    ldiff  = $signed({1'b0, l1_r}) - $signed({1'b0, l4_r});
    neg_z  = 18'sd0 - 18'(in_ch.target_z);
    lift   = {{3{ldiff[10]}}, ldiff, 4'b0};
    h_calc = neg_z + lift;
  end

  // multiplier operand selection
  always_comb begin
    diff_j = 19'(goal_r[j_r]) - 19'(drive_r[j_r]);
    unique case (state_r)
      ST_XX:   begin mul_a = 33'(x_r);  mul_b = 33'(x_r);  end
      ST_YY:   begin mul_a = 33'(y_r);  mul_b = 33'(y_r);  end
      ST_HH:   begin mul_a = 33'(h_r);  mul_b = 33'(h_r);  end
      ST_L22:  begin mul_a = $signed({23'b0, l2_r}); mul_b = $signed({23'b0, l2_r}); end
      ST_L33:  begin mul_a = $signed({23'b0, l3_r}); mul_b = $signed({23'b0, l3_r}); end
      ST_L23:  begin mul_a = $signed({23'b0, l2_r}); mul_b = $signed({23'b0, l3_r}); end
      ST_CC:   begin mul_a = 33'(c_r);  mul_b = 33'(c_r);  end
      ST_LS:   begin mul_a = $signed({23'b0, l3_r}); mul_b = $signed({2'b0, s_r}); end
      ST_LC:   begin mul_a = $signed({23'b0, l3_r}); mul_b = 33'(c_r); end
      ST_TKM:  begin mul_a = 33'(diff_j); mul_b = $signed({17'b0, gain_r}); end
      default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
    endcase
  end

  // operands of the current atan2 pass
  always_comb begin
    unique case (k_r)
      CA_ELBOW: begin cr_y = $signed({13'b0, s_r});  cr_x = 44'(c_r);  end
      CA_REACH: begin cr_y = 44'(h_r);  cr_x = $signed({28'b0, rr_r}); end
      CA_LINK:  begin cr_y = q3y_r;     cr_x = q3x_r;                  end
      CA_BASE:  begin cr_y = 44'(y_r);  cr_x = 44'(x_r);               end
      default:  begin cr_y = 44'sd0;    cr_x = 44'sd0;                 end
    endcase
  end

  // final angles in Q4.13
  always_comb begin
    elbow_q    = rnd_q13(30'(ang_r[CA_ELBOW]));
    shoulder_q = rnd_q13(30'(ang_r[CA_REACH]) - 30'(ang_r[CA_LINK]));
    base_q     = rnd_q13(30'(ang_r[CA_BASE]));
    wrist_q    = HALF_PI_Q13 - (shoulder_q + elbow_q);
  end

  always_comb begin
    den_s   = $signed({6'b0, den_r});
    num_mag = num_r[35] ? 36'(-num_r) : 36'(num_r);
    quot    = {1'b0, ds_result[30:0]};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    h_nxt         = h_r;
    r2_nxt        = r2_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    rr_nxt        = rr_r;
    q3y_nxt       = q3y_r;
    q3x_nxt       = q3x_r;
    ang_nxt       = ang_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    goal_nxt      = goal_r;
    drive_nxt     = drive_r;
    flag_nxt      = flag_r;
    out_goal_nxt  = out_goal_r;
    out_drive_nxt = out_drive_r;
    out_flag_nxt  = out_flag_r;
    // drop the result once the receiver takes it
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ds_req        = '0;
    ds_opa        = 64'd0;
    cr_start      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_TARGET) begin
            x_nxt     = in_ch.target_x;
            y_nxt     = in_ch.target_y;
            h_nxt     = h_calc;
            state_nxt = ST_XX;
          end else begin
            j_nxt     = JNT_BASE;
            state_nxt = ST_TKM;
          end
        end
      end
      ST_XX:  state_nxt = ST_YY;
      ST_YY: begin
        r2_nxt    = prod[32:0];
        state_nxt = ST_HH;
      end
      ST_HH: begin
        r2_nxt    = r2_r + prod[32:0];
        state_nxt = ST_L22;
      end
      ST_L22: begin
        num_nxt   = $signed({3'b0, r2_r}) + 36'(prod);
        state_nxt = ST_L33;
      end
      ST_L33: begin
        num_nxt   = num_r - (36'(prod) <<< 8);
        state_nxt = ST_L23;
      end
      ST_L23: begin
        num_nxt   = num_r - (36'(prod) <<< 8);
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        den_nxt   = {prod[20:0], 9'b0};
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // clamp the cosine when the point is out of reach
        if (num_r > den_s) begin
          c_nxt     = C_ONE;
          flag_nxt  = 1'b1;
          state_nxt = ST_CC;
        end else if (num_r < -den_s) begin
          c_nxt     = -C_ONE;
          flag_nxt  = 1'b1;
          state_nxt = ST_CC;
        end else begin
          flag_nxt = 1'b0;
          if (den_r == 30'd0) begin
            c_nxt     = 32'sd0;
            state_nxt = ST_CC;
          end else begin
            ds_req.start = 1'b1;
            ds_req.mode  = DS_DIV;
            ds_opa       = {28'b0, num_mag};
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (ds_done) begin
          c_nxt     = num_r[35] ? $signed(32'd0 - quot) : $signed(quot);
          state_nxt = ST_CC;
        end
      end
      ST_CC:  state_nxt = ST_SQS;
      ST_SQS: begin
        ds_req.start = 1'b1;
        ds_req.mode  = DS_SQRT;
        ds_opa       = ONE_SQR - 64'(prod);
        state_nxt    = ST_SQW;
      end
      ST_SQW: begin
        if (ds_done) begin
          s_nxt     = ds_result[30:0];
          state_nxt = ST_RS;
        end
      end
      ST_RS: begin
        ds_req.start = 1'b1;
        ds_req.mode  = DS_SQRT;
        ds_opa       = {31'b0, r2_r};
        state_nxt    = ST_RW;
      end
      ST_RW: begin
        if (ds_done) begin
          rr_nxt    = ds_result[15:0];
          state_nxt = ST_LS;
        end
      end
      ST_LS:  state_nxt = ST_LC;
      ST_LC: begin
        q3y_nxt   = prod[43:0];
        state_nxt = ST_LCW;
      end
      ST_LCW: begin
        q3x_nxt   = $signed({4'b0, l2_r, 30'b0}) + prod[43:0];
        k_nxt     = CA_ELBOW;
        state_nxt = ST_CST;
      end
      ST_CST: begin
        cr_start  = 1'b1;
        state_nxt = ST_CWT;
      end
      ST_CWT: begin
        if (cr_done) begin
          ang_nxt[k_r] = cr_angle;
          if (k_r == CA_BASE) begin
            state_nxt = ST_FIN;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_CST;
          end
        end
      end
      ST_FIN: begin
        goal_nxt[JNT_BASE]     = base_q;
        goal_nxt[JNT_SHOULDER] = shoulder_q;
        goal_nxt[JNT_ELBOW]    = elbow_q;
        goal_nxt[JNT_WRIST]    = wrist_q;
        state_nxt              = ST_OUT;
      end
      ST_TKM: state_nxt = ST_TKA;
      ST_TKA: begin
        // advance the drive by the floored step
        drive_nxt[j_r] = drive_r[j_r] + prod[33:16];
        if (j_r == JNT_WRIST) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = ST_TKM;
        end
      end
      ST_OUT: begin
        // hold here until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_goal_nxt  = goal_r;
          out_drive_nxt = drive_r;
          out_flag_nxt  = flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
      goal_r      <= '{default: '0};
      drive_r     <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      flag_r      <= flag_nxt;
      goal_r      <= goal_nxt;
      drive_r     <= drive_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    h_r         <= h_nxt;
    r2_r        <= r2_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    c_r         <= c_nxt;
    s_r         <= s_nxt;
    rr_r        <= rr_nxt;
    q3y_r       <= q3y_nxt;
    q3x_r       <= q3x_nxt;
    ang_r       <= ang_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    out_goal_r  <= out_goal_nxt;
    out_drive_r <= out_drive_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  // configuration registers; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r   <= 10'd185;
      l2_r   <= 10'd165;
      l3_r   <= 10'd150;
      l4_r   <= 10'd60;
      gain_r <= 16'd6554;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BASE_HEIGHT:      l1_r   <= cfg_ch.data[9:0];
        CFG_UPPER_ARM_LENGTH: l2_r   <= cfg_ch.data[9:0];
        CFG_FOREARM_LENGTH:   l3_r   <= cfg_ch.data[9:0];
        CFG_WRIST_OFFSET:     l4_r   <= cfg_ch.data[9:0];
        CFG_SMOOTHING_GAIN:   gain_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.goal_base      = out_goal_r[JNT_BASE];
  assign out_ch.goal_shoulder  = out_goal_r[JNT_SHOULDER];
  assign out_ch.goal_elbow     = out_goal_r[JNT_ELBOW];
  assign out_ch.goal_wrist     = out_goal_r[JNT_WRIST];
  assign out_ch.drive_base     = out_drive_r[JNT_BASE];
  assign out_ch.drive_shoulder = out_drive_r[JNT_SHOULDER];
  assign out_ch.drive_elbow    = out_drive_r[JNT_ELBOW];
  assign out_ch.drive_wrist    = out_drive_r[JNT_WRIST];
  assign out_ch.out_of_reach   = out_flag_r;

`ifndef SYNTHESIS
  a_ds_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    ds_done |-> (state_r == ST_DIV || state_r == ST_SQW || state_r == ST_RW))
    else $error("divide/root result arrived outside a wait state");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cr_done |-> (state_r == ST_CWT))
    else $error("atan2 result arrived outside its wait state");

  a_clamped_cosine: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CC && flag_r) |-> (c_r == C_ONE || c_r == -C_ONE))
    else $error("out-of-reach target without a clamped cosine");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not moved into the result register");
`endif
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for arm_inverse_kinematics_smoother. A bit-true
// predictor solves every target point and smooths every tick. Each output
// transfer is compared field by field with the oldest prediction, across
// several link and gain settings and random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aiks_pkg::*;

  localparam int  STEPS      = 16;
  localparam int  CYCLE_CAP  = 1_000_000;
  localparam int  HOLD_LEN   = 3000;
  localparam int  DRAIN_WAIT = 300;

  // one predicted output transfer
  typedef struct {
    longint goal[4];
    longint drive[4];
    bit     reach;
  } joint_frame_t;

  // --------------------------------------------------------------------------
  // Joint angle scoreboard: own copy of the registers and joint state
  // --------------------------------------------------------------------------
  class joint_angle_board;
    longint       link_l1, link_l2, link_l3, link_l4, gain;
    longint       goal[4];
    longint       drive[4];
    bit           reach;
    joint_frame_t pending_frames[$];
    int           errors;

    function new();
      link_l1 = 185; link_l2 = 165; link_l3 = 150; link_l4 = 60; gain = 6554;
      foreach (goal[i]) begin
        goal[i]  = 0;
        drive[i] = 0;
      end
      reach  = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_BASE_HEIGHT:      link_l1 = longint'(data[9:0]);
        CFG_UPPER_ARM_LENGTH: link_l2 = longint'(data[9:0]);
        CFG_FOREARM_LENGTH:   link_l3 = longint'(data[9:0]);
        CFG_WRIST_OFFSET:     link_l4 = longint'(data[9:0]);
        CFG_SMOOTHING_GAIN:   gain    = longint'(data);
        default: ;
      endcase
    endfunction

    function longint floor_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function longint arc_tan(longint ys, longint xs);
      longint acc, ax, ay, m, nx, ny;
      longint arc_step[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                               262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                               1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      acc = 0;
      if (xs == 0 && ys == 0) return 0;
      // fold the left half plane onto the right one
      if (xs < 0) begin
        acc = (ys >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
        xs = -xs;
        ys = -ys;
      end
      ax = xs;
      ay = (ys < 0) ? -ys : ys;
      m  = (ax > ay) ? ax : ay;
      while (m < (64'sd1 <<< 40)) begin
        xs = xs * 2;
        ys = ys * 2;
        m  = m * 2;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        if (ys >= 0) begin
          nx = xs + (ys >>> i);
          ny = ys - (xs >>> i);
          acc += arc_step[i];
        end else begin
          nx = xs - (ys >>> i);
          ny = ys + (xs >>> i);
          acc -= arc_step[i];
        end
        xs = nx;
        ys = ny;
      end
      return acc;
    endfunction

    function longint to_q13(longint v);
      return (v + 1024) >>> 11;
    endfunction

    function void solve_joint_goals(longint x, longint y, longint z);
      longint h, r2, rad, num, den, c, s, el, sh;
      longint one;
      one = 64'sd1 <<< 30;
      h   = -z + (link_l1 - link_l4) * 16;
      r2  = x * x + y * y;
      rad = floor_sqrt(r2);
      num = r2 + h * h - 256 * (link_l2 * link_l2 + link_l3 * link_l3);
      den = 512 * link_l2 * link_l3;
      // clamp the cosine and raise the flag when the point is out of reach
      if (num > den) begin
        c = one;
        reach = 1;
      end else if (num < -den) begin
        c = -one;
        reach = 1;
      end else begin
        reach = 0;
        c = (den == 0) ? 0 : (num * one) / den;
      end
      s  = floor_sqrt(64'(one * one - c * c));
      el = to_q13(arc_tan(s, c));
      sh = to_q13(arc_tan(h, rad) - arc_tan(link_l3 * s, link_l2 * one + link_l3 * c));
      goal[0] = to_q13(arc_tan(y, x));
      goal[1] = sh;
      goal[2] = el;
      goal[3] = longint'(HALF_PI_Q13) - (sh + el);
    endfunction

    function void note_item(logic op, coord_t x, coord_t y, coord_t z);
      joint_frame_t f;
      if (op == OP_TARGET) begin
        solve_joint_goals(longint'(x), longint'(y), longint'(z));
      end else begin
        foreach (drive[i]) drive[i] += ((goal[i] - drive[i]) * gain) >>> 16;
      end
      f.goal  = goal;
      f.drive = drive;
      f.reach = reach;
      pending_frames.push_back(f);
    endfunction

    function void check_frame(angle_t g[4], angle_t d[4], logic r);
      joint_frame_t f;
      string joint[4] = '{"base", "shoulder", "elbow", "wrist"};
      if (pending_frames.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $realtime);
        errors++;
        return;
      end
      f = pending_frames.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (g[i] !== angle_t'(f.goal[i])) begin
          $display("%0t: goal_%s expected %0d actual %0d", $realtime, joint[i],
                   angle_t'(f.goal[i]), g[i]);
          errors++;
        end
        if (d[i] !== angle_t'(f.drive[i])) begin
          $display("%0t: drive_%s expected %0d actual %0d", $realtime, joint[i],
                   angle_t'(f.drive[i]), d[i]);
          errors++;
        end
      end
      if (r !== f.reach) begin
        $display("%0t: out_of_reach expected %0d actual %0d", $realtime, f.reach, r);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  always #5 clk = ~clk;

  aiks_in_if  in_ch();
  aiks_out_if out_ch();
  aiks_cfg_if cfg_ch();

  arm_inverse_kinematics_smoother #(.CORDIC_STEPS(STEPS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  joint_angle_board board = new();

  bit quiet;        // suppress random idling on both sides
  bit hold_request; // ask the receiver for one long hold-off
  int cycles;

  // Watchdog: end the run if it drags on far past the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: check every result transfer, then pick ready for the next edge.
  // Values read right after the edge are the ones the flops sampled.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    angle_t g[4], d[4];
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        g = '{out_ch.goal_base, out_ch.goal_shoulder, out_ch.goal_elbow, out_ch.goal_wrist};
        d = '{out_ch.drive_base, out_ch.drive_shoulder, out_ch.drive_elbow,
              out_ch.drive_wrist};
        board.check_frame(g, d, out_ch.out_of_reach);
      end
      if (hold_request) begin
        hold_left = HOLD_LEN;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 9) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic send_item(logic op, coord_t x, coord_t y, coord_t z);
    // random gap before the item; valid drops only for a real gap
    if (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.target_x  <= x;
    in_ch.target_y  <= y;
    in_ch.target_z  <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(op, x, y, z);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Let every expected transfer arrive, then a latency's worth of cycles.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic write_links(logic [15:0] l1, logic [15:0] l2, logic [15:0] l3,
                             logic [15:0] l4, logic [15:0] g);
    write_reg(CFG_BASE_HEIGHT, l1);
    write_reg(CFG_UPPER_ARM_LENGTH, l2);
    write_reg(CFG_FOREARM_LENGTH, l3);
    write_reg(CFG_WRIST_OFFSET, l4);
    write_reg(CFG_SMOOTHING_GAIN, g);
    cfg_ch.valid <= 1'b0;
  endtask

  // Coordinate within +-span mm (Q12.4), saturated to the field range.
  function automatic coord_t near_coord(int span_mm);
    int v;
    v = $urandom_range(span_mm * 32) - span_mm * 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  // Mostly targets inside the workspace and runs of ticks, some full-range noise.
  task automatic random_burst(int n);
    int span, roll;
    span = int'(board.link_l2 + board.link_l3 + board.link_l1) + 20;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_tick();
      end else if (roll < 85) begin
        send_item(OP_TARGET, near_coord(span), near_coord(span), near_coord(span));
      end else begin
        send_item(OP_TARGET, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TARGET;
    in_ch.target_x  <= '0;
    in_ch.target_y  <= '0;
    in_ch.target_z  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default links: tick before any target, origin, extremes, both half planes
    send_tick();
    send_item(OP_TARGET, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_TARGET, 16'sd32767, 16'sd0, 16'sd0);
    send_item(OP_TARGET, -16'sd32768, 16'sd0, 16'sd0);
    send_item(OP_TARGET, -16'sd1600, -16'sd16, 16'sd0);
    send_item(OP_TARGET, 16'sd0, 16'sd32767, -16'sd32768);
    send_item(OP_TARGET, 16'sd0, -16'sd32768, 16'sd32767);
    send_item(OP_TARGET, 16'sd3200, 16'sd1600, -16'sd800);
    repeat (3) send_tick();
    drain();

    // long links against a unit forearm, full gain; bits above width dropped
    write_links(16'hFFFF, 16'hFFFF, 16'hFC01, 16'hFC00, 16'hFFFF);
    send_item(OP_TARGET, 16'sd0, 16'sd0, 16'sd16368);   // too close to reach
    repeat (2) send_tick();
    send_item(OP_TARGET, 16'sd32767, 16'sd32767, 16'sd0); // too far to reach
    repeat (3) send_tick();
    drain();

    // zero link product with the point at the shoulder, zero gain
    write_links(16'd500, 16'h0400, 16'h0400, 16'd500, 16'd0);
    send_item(OP_TARGET, 16'sd0, 16'sd0, 16'sd0);
    send_tick();
    drain();

    // random settings, the middle one with no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      write_links(16'($urandom), 16'($urandom_range(1023, 1)), 16'($urandom_range(1023, 1)),
                  16'($urandom), 16'($urandom));
      quiet = (ph == 1);
      random_burst(150);
      drain();
    end
    quiet = 0;

    // defaults again; hold off the receiver so the block backs up its input
    write_links(16'd185, 16'd165, 16'd150, 16'd60, 16'd6554);
    hold_request = 1;
    random_burst(150);
    drain();

    if (board.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== arm_inverse_kinematics_smoother.f =====
src/aiks_pkg.sv
src/aiks_ifs.sv
src/aiks_mul.sv
src/aiks_divsqrt.sv
src/aiks_cordic.sv
src/arm_inverse_kinematics_smoother.sv
tb/tb_top.sv
